[hw/rtl/vertex_clip_screen_transform_defines.svh]
// Assertion macros for the vertex transform RTL.
`ifndef VERTEX_CLIP_SCREEN_TRANSFORM_DEFINES_SVH
`define VERTEX_CLIP_SCREEN_TRANSFORM_DEFINES_SVH

// Condition in one cycle implies consequence in the next.
`define VCST_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("vcst: next-cycle check failed");

// Condition in one cycle implies the signal holds its value into the next.
`define VCST_ASSERT_HOLD(lbl, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error("vcst: hold check failed");

`endif

[hw/rtl/vcst_pkg.sv]
// Types and constants for the vertex transform and perspective divide block.
package vcst_pkg;

	localparam int DIM_W  = 13;
	localparam int PROD_W = 64;
	localparam int SUM_W  = 66;
	localparam int CLIP_W = 48;
	localparam int SCR_W  = 62;
	localparam int NUM_W  = 63;
	localparam int MAG_W  = 62;
	localparam int DEN_W  = 49;
	localparam int QBITS  = 33;
	localparam int DIV_LAT = QBITS + 2;
	localparam int LANES  = 3;

	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_Z = 2;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_VERTEX = 1'b1;

	localparam logic REG_RENDER_WIDTH  = 1'b0;
	localparam logic REG_RENDER_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

	localparam logic signed [SUM_W-1:0] CLIP_HI =
		{{(SUM_W-CLIP_W+1){1'b0}}, {(CLIP_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] CLIP_LO =
		{{(SUM_W-CLIP_W+1){1'b1}}, {(CLIP_W-1){1'b0}}};

	typedef struct packed {
		logic               command;
		logic [3:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic signed [31:0] vert_w;
		logic               last_vertex;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] depth;
		logic               divide_fault;
		logic               last_out;
	} out_item_t;

	typedef struct packed {
		logic vld;
		logic last;
		logic fault;
	} side_t;

endpackage

[hw/rtl/vcst_div.sv]
// Pipelined fixed point divider: one quotient bit per stage, saturating.
module vcst_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [vcst_pkg::MAG_W-1:0]  mag,
	input  logic [vcst_pkg::DEN_W-1:0]  den,
	input  logic                        neg,
	input  logic                        zero,
	input  logic                        num_neg,
	output logic signed [31:0]          quot,
	output logic                        fault
);
	import vcst_pkg::*;

	localparam int SH = QBITS - FRAC_BITS;

	logic [MAG_W-1:0]           hi;
	logic [MAG_W+FRAC_BITS-1:0] nfull;

	logic [DEN_W-1:0] rem_sd  [QBITS+1];
	logic [QBITS-1:0] nlo_sd  [QBITS+1];
	logic [QBITS-1:0] q_sd    [QBITS+1];
	logic [DEN_W-1:0] den_sd  [QBITS+1];
	logic             ovf_sd  [QBITS+1];
	logic             neg_sd  [QBITS+1];
	logic             zero_sd [QBITS+1];
	logic             nneg_sd [QBITS+1];

	logic [QBITS-1:0] lim;

	assign hi    = mag >> SH;
	assign nfull = {mag, {FRAC_BITS{1'b0}}};

	// Quotient fits in QBITS bits exactly when the high part stays below the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0]  <= hi[DEN_W-1:0];
			nlo_sd[0]  <= nfull[QBITS-1:0];
			q_sd[0]    <= '0;
			den_sd[0]  <= den;
			ovf_sd[0]  <= hi >= MAG_W'(den);
			neg_sd[0]  <= neg;
			zero_sd[0] <= zero;
			nneg_sd[0] <= num_neg;
		end
	end

	for (genvar i = 0; i < QBITS; i++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		assign trial = {rem_sd[i], nlo_sd[i][QBITS-1]};
		assign ge    = trial >= {1'b0, den_sd[i]};
		assign diff  = trial - {1'b0, den_sd[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[i+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				nlo_sd[i+1]  <= {nlo_sd[i][QBITS-2:0], 1'b0};
				q_sd[i+1]    <= {q_sd[i][QBITS-2:0], ge};
				den_sd[i+1]  <= den_sd[i];
				ovf_sd[i+1]  <= ovf_sd[i];
				neg_sd[i+1]  <= neg_sd[i];
				zero_sd[i+1] <= zero_sd[i];
				nneg_sd[i+1] <= nneg_sd[i];
			end
		end
	end

	assign lim = neg_sd[QBITS] ? (QBITS'(1) << 31) : ((QBITS'(1) << 31) - QBITS'(1));

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_sd[QBITS]) begin
				fault <= 1'b1;
				quot  <= nneg_sd[QBITS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else if (ovf_sd[QBITS] || q_sd[QBITS] > lim) begin
				fault <= 1'b1;
				quot  <= neg_sd[QBITS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				fault <= 1'b0;
				quot  <= neg_sd[QBITS] ? -$signed(q_sd[QBITS][31:0])
					: $signed(q_sd[QBITS][31:0]);
			end
		end
	end

endmodule

[hw/rtl/vertex_clip_screen_transform.sv]
// Top level: clip matrix store, transform pipeline and perspective divide.
//
// Input channel in_valid/in_ready/in_data carries two kinds of transaction.
// A write (command 0) stores entry_value into the column-major clip matrix
// at entry_index; it takes effect for the very next vertex and gives no result.
// A vertex (command 1) is multiplied by the matrix, mapped to screen space with
// the render size and divided by clip w; one result leaves on out_valid/
// out_ready/out_data for each accepted vertex. Throughput is one transaction
// per cycle unless the receiver stalls: six arithmetic stages, a 35 stage
// divider that resolves one quotient bit per stage, and an output register.
// The config port (cfg_we, cfg_idx, cfg_wdata) writes render width (index 0)
// or height (index 1); write it only while the pipeline is empty.
// Reset loads the identity matrix and a 640 x 480 render size and empties the
// pipeline. When the receiver holds out_ready low with a result waiting, the
// whole pipeline freezes and in_ready drops; nothing is lost or repeated.
module vertex_clip_screen_transform #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  vcst_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vcst_pkg::out_item_t           out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [vcst_pkg::DIM_W-1:0]    cfg_wdata
);
	import vcst_pkg::*;

	logic adv;
	logic in_fire;

	logic [31:0]      mat_q [16];
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	logic signed [31:0] vert [4];

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                     last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic                     fault_s3, fault_s4, fault_s5, fault_s6;
	logic signed [PROD_W-1:0] prod_s1 [16];
	logic signed [SUM_W-1:0]  sum_s2 [4];
	logic signed [CLIP_W-1:0] clip_s3 [4];
	logic signed [SCR_W-1:0]  px_s4, pwx_s4, py_s4, pwy_s4;
	logic signed [CLIP_W-1:0] cz_s4, cw_s4, cz_s5, cw_s5;
	logic signed [NUM_W-1:0]  nx_s5, ny_s5;
	logic [MAG_W-1:0]         mag_s6 [LANES];
	logic [DEN_W-1:0]         den_s6 [LANES];
	logic                     neg_s6 [LANES];
	logic                     nneg_s6 [LANES];
	logic                     zero_s6;

	logic signed [DIM_W:0]    wm1, hm1;
	logic signed [SUM_W-1:0]  tclip [4];
	logic                     sat [4];
	logic signed [NUM_W-1:0]  nxa, nya;
	logic signed [CLIP_W-1:0] cza, cwa;

	side_t              side_sd [DIV_LAT];
	logic signed [31:0] quot [LANES];
	logic               dfault [LANES];

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign in_fire  = in_valid && in_ready;

	assign vert[0] = in_data.vert_x;
	assign vert[1] = in_data.vert_y;
	assign vert[2] = in_data.vert_z;
	assign vert[3] = in_data.vert_w;

	// Matrix and render size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= (i % 5 == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
			end
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else begin
			if (in_fire && in_data.command == CMD_WRITE) begin
				mat_q[in_data.entry_index] <= in_data.entry_value;
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_RENDER_WIDTH:  width_q  <= cfg_wdata;
					REG_RENDER_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// Valid bits, side band and stage faults.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				side_sd[i] <= '0;
			end
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_fire && in_data.command == CMD_VERTEX;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			side_sd[0] <= '{vld: vld_s6, last: last_s6, fault: fault_s6};
			for (int i = 1; i < DIV_LAT; i++) begin
				side_sd[i] <= side_sd[i-1];
			end
			out_valid <= side_sd[DIV_LAT-1].vld;
		end
	end

	// Stage 1: sixteen exact products, matrix sampled at acceptance.
	for (genvar k = 0; k < 16; k++) begin : g_mul
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s1[k] <= $signed(mat_q[k]) * vert[k/4];
			end
		end
	end

	// Stage 3 combinational: floor to the fraction and saturate each clip value.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			tclip[r] = sum_s2[r] >>> FRAC_BITS;
			sat[r]   = tclip[r] > CLIP_HI || tclip[r] < CLIP_LO;
		end
	end

	assign wm1 = $signed({1'b0, width_q}) - 14'sd1;
	assign hm1 = $signed({1'b0, height_q}) - 14'sd1;

	// Stage 6 combinational: magnitudes and signs for the divider lanes.
	assign nxa = nx_s5[NUM_W-1] ? -nx_s5 : nx_s5;
	assign nya = ny_s5[NUM_W-1] ? -ny_s5 : ny_s5;
	assign cza = cz_s5[CLIP_W-1] ? -cz_s5 : cz_s5;
	assign cwa = cw_s5[CLIP_W-1] ? -cw_s5 : cw_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= in_data.last_vertex;

			last_s2 <= last_s1;
			for (int r = 0; r < 4; r++) begin
				sum_s2[r] <= SUM_W'(prod_s1[r]) + SUM_W'(prod_s1[r+4])
					+ SUM_W'(prod_s1[r+8]) + SUM_W'(prod_s1[r+12]);
			end

			last_s3  <= last_s2;
			fault_s3 <= sat[0] || sat[1] || sat[2] || sat[3];
			for (int r = 0; r < 4; r++) begin
				clip_s3[r] <= sat[r] ? (tclip[r][SUM_W-1] ? CLIP_LO[CLIP_W-1:0]
					: CLIP_HI[CLIP_W-1:0]) : tclip[r][CLIP_W-1:0];
			end

			last_s4  <= last_s3;
			fault_s4 <= fault_s3;
			px_s4    <= clip_s3[0] * $signed({1'b0, width_q});
			pwx_s4   <= clip_s3[3] * wm1;
			py_s4    <= clip_s3[1] * $signed({1'b0, height_q});
			pwy_s4   <= clip_s3[3] * hm1;
			cz_s4    <= clip_s3[2];
			cw_s4    <= clip_s3[3];

			last_s5  <= last_s4;
			fault_s5 <= fault_s4;
			nx_s5    <= NUM_W'(px_s4) + NUM_W'(pwx_s4);
			ny_s5    <= NUM_W'(pwy_s4) - NUM_W'(py_s4);
			cz_s5    <= cz_s4;
			cw_s5    <= cw_s4;

			last_s6  <= last_s5;
			fault_s6 <= fault_s5;
			zero_s6  <= cw_s5 == '0;
			mag_s6[LANE_X]  <= nxa[MAG_W-1:0];
			mag_s6[LANE_Y]  <= nya[MAG_W-1:0];
			mag_s6[LANE_Z]  <= MAG_W'(unsigned'(cza));
			den_s6[LANE_X]  <= {cwa, 1'b0};
			den_s6[LANE_Y]  <= {cwa, 1'b0};
			den_s6[LANE_Z]  <= {1'b0, cwa};
			nneg_s6[LANE_X] <= nx_s5[NUM_W-1];
			nneg_s6[LANE_Y] <= ny_s5[NUM_W-1];
			nneg_s6[LANE_Z] <= cz_s5[CLIP_W-1];
			neg_s6[LANE_X]  <= nx_s5[NUM_W-1] != cw_s5[CLIP_W-1];
			neg_s6[LANE_Y]  <= ny_s5[NUM_W-1] != cw_s5[CLIP_W-1];
			neg_s6[LANE_Z]  <= cz_s5[CLIP_W-1] != cw_s5[CLIP_W-1];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_div
		vcst_div #(
			.FRAC_BITS(FRAC_BITS)
		) u_div (
			.clk     (clk),
			.en      (adv),
			.mag     (mag_s6[l]),
			.den     (den_s6[l]),
			.neg     (neg_s6[l]),
			.zero    (zero_s6),
			.num_neg (nneg_s6[l]),
			.quot    (quot[l]),
			.fault   (dfault[l])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.screen_x     <= quot[LANE_X];
			out_data.screen_y     <= quot[LANE_Y];
			out_data.depth        <= quot[LANE_Z];
			out_data.divide_fault <= side_sd[DIV_LAT-1].fault || dfault[LANE_X]
				|| dfault[LANE_Y] || dfault[LANE_Z];
			out_data.last_out     <= side_sd[DIV_LAT-1].last;
		end
	end

	`include "vertex_clip_screen_transform_defines.svh"

	`VCST_ASSERT_NEXT(a_write_no_result, in_fire && in_data.command == CMD_WRITE, !vld_s1)
	`VCST_ASSERT_NEXT(a_vertex_enters, in_fire && in_data.command == CMD_VERTEX, vld_s1)
	`VCST_ASSERT_HOLD(a_stall_freezes_s3, !adv, vld_s3)
	`VCST_ASSERT_HOLD(a_stall_freezes_tail, !adv, side_sd[DIV_LAT-1])

endmodule
